@@ hw/rtl/sphere_obb_collision_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef SPHERE_OBB_COLLISION_MACROS_SVH
`define SPHERE_OBB_COLLISION_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SOC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sphere_obb_collision: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SOC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sphere_obb_collision: next-cycle check failed");

`endif

@@ hw/rtl/soc_pkg.sv @@
package soc_pkg;

    localparam logic [1:0] REQ_VERTEX = 2'd0;
    localparam logic [1:0] REQ_QUERY  = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    localparam logic [2:0] CFG_OFFSET_X = 3'd0;
    localparam logic [2:0] CFG_OFFSET_Y = 3'd1;
    localparam logic [2:0] CFG_OFFSET_Z = 3'd2;
    localparam logic [2:0] CFG_ROT_COS  = 3'd3;
    localparam logic [2:0] CFG_ROT_SIN  = 3'd4;

    localparam logic signed [15:0] ROT_COS_RESET = 16'sd16384;

    localparam logic [5:0] ROT_LAST  = 6'd8;
    localparam logic [5:0] AXIS_LAST = 6'd2;
    localparam logic [5:0] SQRT_LAST = 6'd31;
    localparam logic [5:0] DIV_LAST  = 6'd63;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CENTER,
        ST_ROT,
        ST_RES,
        ST_SQ,
        ST_CMP,
        ST_SQRT,
        ST_LEN,
        ST_PROD,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CENTER,
        OP_ROT,
        OP_RES,
        OP_SQ,
        OP_CMP,
        OP_SQRT,
        OP_LEN,
        OP_PROD,
        OP_DIV,
        OP_OUT
    } op_t;

    typedef struct packed {
        logic       accept;
        op_t        op;
        logic [5:0] step;
    } cmd_t;

    typedef struct packed {
        logic have;
        logic hit;
        logic len_zero;
        logic out_free;
    } status_t;

endpackage

@@ hw/rtl/soc_ctrl.sv @@
module soc_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic [1:0]        s_tuser,
    output logic              s_tready,
    input  soc_pkg::status_t  status,
    output soc_pkg::cmd_t     cmd
);

    soc_pkg::state_t state_reg, state_next;
    logic [5:0]      step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= soc_pkg::ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg + 6'd1;
        s_tready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.op     = soc_pkg::OP_NONE;
        cmd.step   = step_reg;
        case (state_reg)
            soc_pkg::ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                step_next  = '0;
                if (s_tvalid && s_tuser == soc_pkg::REQ_QUERY)
                begin
                    state_next = status.have ? soc_pkg::ST_CENTER : soc_pkg::ST_OUT;
                end
            end
            soc_pkg::ST_CENTER:
            begin
                cmd.op     = soc_pkg::OP_CENTER;
                step_next  = '0;
                state_next = soc_pkg::ST_ROT;
            end
            soc_pkg::ST_ROT:
            begin
                cmd.op = soc_pkg::OP_ROT;
                if (step_reg == soc_pkg::ROT_LAST)
                begin
                    state_next = soc_pkg::ST_RES;
                end
            end
            soc_pkg::ST_RES:
            begin
                cmd.op     = soc_pkg::OP_RES;
                step_next  = '0;
                state_next = soc_pkg::ST_SQ;
            end
            soc_pkg::ST_SQ:
            begin
                cmd.op = soc_pkg::OP_SQ;
                if (step_reg == soc_pkg::AXIS_LAST)
                begin
                    state_next = soc_pkg::ST_CMP;
                end
            end
            soc_pkg::ST_CMP:
            begin
                cmd.op     = soc_pkg::OP_CMP;
                step_next  = '0;
                state_next = status.hit ? soc_pkg::ST_SQRT : soc_pkg::ST_OUT;
            end
            soc_pkg::ST_SQRT:
            begin
                cmd.op = soc_pkg::OP_SQRT;
                if (step_reg == soc_pkg::SQRT_LAST)
                begin
                    state_next = soc_pkg::ST_LEN;
                end
            end
            soc_pkg::ST_LEN:
            begin
                // A hit at zero distance keeps a zero normal.
                cmd.op     = soc_pkg::OP_LEN;
                step_next  = '0;
                state_next = status.len_zero ? soc_pkg::ST_OUT : soc_pkg::ST_PROD;
            end
            soc_pkg::ST_PROD:
            begin
                cmd.op = soc_pkg::OP_PROD;
                if (step_reg == soc_pkg::AXIS_LAST)
                begin
                    step_next  = '0;
                    state_next = soc_pkg::ST_DIV;
                end
            end
            soc_pkg::ST_DIV:
            begin
                cmd.op = soc_pkg::OP_DIV;
                if (step_reg == soc_pkg::DIV_LAST)
                begin
                    state_next = soc_pkg::ST_OUT;
                end
            end
            soc_pkg::ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = soc_pkg::OP_OUT;
                    state_next = soc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = soc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/soc_datapath.sv @@
module soc_datapath
(
    input  logic              clk,
    input  logic              rst_n,
    input  soc_pkg::cmd_t     cmd,
    output soc_pkg::status_t  status,
    input  logic [1:0]        req_type,
    input  logic [127:0]      req_data,
    input  logic              cfg_valid,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [95:0]       m_tdata,
    output logic [1:0]        m_tuser
);

    // Configuration and bounds
    logic signed [31:0] off_reg [3];
    logic signed [15:0] cos_reg, sin_reg;
    logic signed [31:0] bmin_reg [3];
    logic signed [31:0] bmax_reg [3];
    logic               have_reg;

    // Query working registers
    logic signed [31:0] pos_reg [3];
    logic [30:0]        rad_reg;
    logic [31:0]        e_reg [3];
    logic signed [34:0] d_reg [3];
    logic signed [32:0] p_reg [3];
    logic signed [37:0] b_reg [3];
    logic signed [51:0] mac_reg;
    logic [31:0]        a_reg [3];
    logic               over_reg [3];
    logic               neg_reg [3];
    logic [63:0]        dist2_reg;
    logic [63:0]        sx_reg;
    logic [31:0]        root_reg;
    logic [34:0]        srem_reg;
    logic [30:0]        intr_reg;
    logic [63:0]        dvd_reg [3];
    logic [32:0]        drem_reg [3];
    logic [31:0]        q_reg [3];
    logic               empty_reg, hit_reg, normal_ok_reg;

    // Output register
    logic               m_tvalid_reg;
    logic [95:0]        m_tdata_reg;
    logic [1:0]         m_tuser_reg;

    logic [1:0]         idx;
    logic signed [34:0] opa;
    logic signed [15:0] opb;
    logic signed [50:0] mprod;
    logic signed [51:0] mac_next;
    logic signed [51:0] mac_rnd;
    logic signed [37:0] rnd_v;
    logic [31:0]        um_a, um_b;
    logic [63:0]        um_p;
    logic               hit_comb;
    logic [34:0]        s_rem_t, s_trial;
    logic               out_free;

    function automatic logic signed [32:0] clamp_e(input logic signed [37:0] v,
                                                   input logic [31:0] e);
        logic signed [37:0] ep;
        logic signed [37:0] r;
        ep = $signed({6'b0, e});
        r  = v;
        if (v > ep)
        begin
            r = ep;
        end
        else if (v < -ep)
        begin
            r = -ep;
        end
        return r[32:0];
    endfunction

    assign idx = cmd.step[1:0];

    // Rotation multiply-accumulate: one signed product per cycle.
    always_comb
    begin
        opa = d_reg[0];
        opb = cos_reg;
        case (cmd.step)
            6'd0: begin opa = d_reg[0];               opb = cos_reg; end
            6'd1: begin opa = d_reg[2];               opb = sin_reg; end
            6'd2: begin opa = d_reg[0];               opb = sin_reg; end
            6'd3: begin opa = d_reg[2];               opb = cos_reg; end
            6'd4: begin opa = 35'(p_reg[0]);          opb = cos_reg; end
            6'd5: begin opa = 35'(p_reg[2]);          opb = sin_reg; end
            6'd6: begin opa = 35'(p_reg[2]);          opb = cos_reg; end
            6'd7: begin opa = 35'(p_reg[0]);          opb = sin_reg; end
            default: begin opa = d_reg[0];            opb = cos_reg; end
        endcase
    end

    assign mprod = opa * opb;

    always_comb
    begin
        logic signed [51:0] base;
        logic signed [51:0] term;
        base = (cmd.step[0] == 1'b0) ? 52'sd0 : mac_reg;
        term = 52'(mprod);
        if (cmd.step == 6'd1 || cmd.step == 6'd7)
        begin
            term = -term;
        end
        mac_next = base + term;
    end

    assign mac_rnd = mac_reg + 52'sd8192;
    assign rnd_v   = mac_rnd[51:14];

    // Shared unsigned multiplier for squares, squared radius and normal scaling.
    always_comb
    begin
        um_a = a_reg[idx];
        um_b = a_reg[idx];
        case (cmd.op)
            soc_pkg::OP_CMP:
            begin
                um_a = {1'b0, rad_reg};
                um_b = {1'b0, rad_reg};
            end
            soc_pkg::OP_PROD:
            begin
                um_b = {1'b0, intr_reg};
            end
            default:
            begin
                um_a = a_reg[idx];
                um_b = a_reg[idx];
            end
        endcase
    end

    assign um_p     = um_a * um_b;
    assign hit_comb = dist2_reg <= um_p;

    assign s_rem_t = {srem_reg[32:0], sx_reg[63:62]};
    assign s_trial = {1'b0, root_reg, 2'b01};

    assign out_free = !m_tvalid_reg || m_tready;

    assign status.have     = have_reg;
    assign status.hit      = hit_comb;
    assign status.len_zero = (root_reg == 32'd0);
    assign status.out_free = out_free;

    // Control state: configuration, bounds, flags and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                off_reg[i]  <= '0;
                bmin_reg[i] <= 32'sh7FFF_FFFF;
                bmax_reg[i] <= 32'sh8000_0000;
            end
            cos_reg       <= soc_pkg::ROT_COS_RESET;
            sin_reg       <= '0;
            have_reg      <= 1'b0;
            empty_reg     <= 1'b0;
            hit_reg       <= 1'b0;
            normal_ok_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    soc_pkg::CFG_OFFSET_X: off_reg[0] <= cfg_data;
                    soc_pkg::CFG_OFFSET_Y: off_reg[1] <= cfg_data;
                    soc_pkg::CFG_OFFSET_Z: off_reg[2] <= cfg_data;
                    soc_pkg::CFG_ROT_COS:  cos_reg    <= cfg_data[15:0];
                    soc_pkg::CFG_ROT_SIN:  sin_reg    <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (cmd.accept)
            begin
                case (req_type)
                    soc_pkg::REQ_VERTEX:
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            if ($signed(req_data[32*i +: 32]) < bmin_reg[i])
                            begin
                                bmin_reg[i] <= req_data[32*i +: 32];
                            end
                            if ($signed(req_data[32*i +: 32]) > bmax_reg[i])
                            begin
                                bmax_reg[i] <= req_data[32*i +: 32];
                            end
                        end
                        have_reg <= 1'b1;
                    end
                    soc_pkg::REQ_CLEAR:
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            bmin_reg[i] <= 32'sh7FFF_FFFF;
                            bmax_reg[i] <= 32'sh8000_0000;
                        end
                        have_reg <= 1'b0;
                    end
                    soc_pkg::REQ_QUERY:
                    begin
                        empty_reg     <= !have_reg;
                        hit_reg       <= 1'b0;
                        normal_ok_reg <= 1'b0;
                    end
                    default: ;
                endcase
            end
            if (cmd.op == soc_pkg::OP_CMP)
            begin
                hit_reg <= hit_comb;
            end
            if (cmd.op == soc_pkg::OP_DIV && cmd.step == soc_pkg::DIV_LAST)
            begin
                normal_ok_reg <= 1'b1;
            end
            if (cmd.op == soc_pkg::OP_OUT)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= req_data[32*i +: 32];
            end
            rad_reg <= req_data[126:96];
        end
        case (cmd.op)
            soc_pkg::OP_CENTER:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    logic signed [32:0] span;
                    logic signed [34:0] ctr;
                    span     = 33'(bmax_reg[i]) - 33'(bmin_reg[i]);
                    e_reg[i] <= span[32:1];
                    ctr      = 35'(off_reg[i]) + 35'(bmin_reg[i])
                             + $signed({3'b0, span[32:1]});
                    d_reg[i] <= 35'(pos_reg[i]) - ctr;
                end
            end
            soc_pkg::OP_ROT:
            begin
                if (cmd.step != soc_pkg::ROT_LAST)
                begin
                    mac_reg <= mac_next;
                end
                case (cmd.step)
                    6'd0: p_reg[1] <= clamp_e(38'(d_reg[1]), e_reg[1]);
                    6'd2: p_reg[0] <= clamp_e(rnd_v, e_reg[0]);
                    6'd4: p_reg[2] <= clamp_e(rnd_v, e_reg[2]);
                    6'd6: b_reg[0] <= rnd_v;
                    6'd8: b_reg[2] <= rnd_v;
                    default: ;
                endcase
            end
            soc_pkg::OP_RES:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    logic signed [38:0] r;
                    logic [38:0]        ab;
                    if (i == 1)
                    begin
                        r = 39'(d_reg[i]) - 39'(p_reg[1]);
                    end
                    else
                    begin
                        r = 39'(d_reg[i]) - 39'(b_reg[i]);
                    end
                    ab          = r[38] ? 39'(-r) : 39'(r);
                    neg_reg[i]  <= r[38];
                    a_reg[i]    <= ab[31:0];
                    over_reg[i] <= |ab[38:32];
                end
            end
            soc_pkg::OP_SQ:
            begin
                logic [64:0] sum;
                sum = (idx == 2'd0) ? {1'b0, um_p}
                                    : ({1'b0, dist2_reg} + {1'b0, um_p});
                if (over_reg[idx] || sum[64])
                begin
                    dist2_reg <= '1;
                end
                else
                begin
                    dist2_reg <= sum[63:0];
                end
            end
            soc_pkg::OP_CMP:
            begin
                sx_reg   <= dist2_reg;
                root_reg <= '0;
                srem_reg <= '0;
            end
            soc_pkg::OP_SQRT:
            begin
                sx_reg <= {sx_reg[61:0], 2'b00};
                if (s_rem_t >= s_trial)
                begin
                    srem_reg <= s_rem_t - s_trial;
                    root_reg <= {root_reg[30:0], 1'b1};
                end
                else
                begin
                    srem_reg <= s_rem_t;
                    root_reg <= {root_reg[30:0], 1'b0};
                end
            end
            soc_pkg::OP_LEN:
            begin
                intr_reg <= rad_reg - root_reg[30:0];
            end
            soc_pkg::OP_PROD:
            begin
                dvd_reg[idx]  <= um_p;
                drem_reg[idx] <= '0;
                q_reg[idx]    <= '0;
            end
            soc_pkg::OP_DIV:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    logic [32:0] t;
                    t          = {drem_reg[i][31:0], dvd_reg[i][63]};
                    dvd_reg[i] <= {dvd_reg[i][62:0], 1'b0};
                    if (t >= {1'b0, root_reg})
                    begin
                        drem_reg[i] <= t - {1'b0, root_reg};
                        q_reg[i]    <= {q_reg[i][30:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg[i] <= t;
                        q_reg[i]    <= {q_reg[i][30:0], 1'b0};
                    end
                end
            end
            soc_pkg::OP_OUT:
            begin
                m_tuser_reg <= {empty_reg, hit_reg};
                for (int i = 0; i < 3; i++)
                begin
                    if (normal_ok_reg)
                    begin
                        m_tdata_reg[32*i +: 32] <= neg_reg[i] ? (32'd0 - q_reg[i]) : q_reg[i];
                    end
                    else
                    begin
                        m_tdata_reg[32*i +: 32] <= '0;
                    end
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

@@ hw/rtl/sphere_obb_collision.sv @@
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    tuser req_type; tdata pos_x, pos_y, pos_z, radius
// m_*       out  m_tvalid/m_tready    tuser collided, empty_bounds; tdata normal_x..z
// cfg_*     in   cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
// Vertex, clear and unused requests are taken in the idle state. A hit query runs through
// the square root and then the three dividers in parallel before its result; a miss ends
// after compare, a zero-distance hit after the root, and a query with no vertex at once.
// rst_n resets bounds, configuration and the output valid asynchronously.
// The result waits in the output register; vertices are still taken meanwhile,
// and a finished query holds until the output register frees up.
module sphere_obb_collision
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // pos_x, pos_y, pos_z, radius, one zero pad bit
    input  logic [1:0]   s_tuser,   // req_type
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // normal_x, normal_y, normal_z
    output logic [1:0]   m_tuser,   // collided, empty_bounds
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    soc_pkg::cmd_t    cmd;
    soc_pkg::status_t status;

    assign cfg_ready = 1'b1;

    soc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    soc_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .req_type  (s_tuser),
        .req_data  (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

@@ hw/rtl/soc_checker.sv @@
`include "sphere_obb_collision_macros.svh"

module soc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // A query against empty bounds never reports a hit.
    `SOC_ASSERT_IMP(a_empty_no_hit, clk, rst_n, m_tvalid && m_tuser[1], !m_tuser[0])

    // Without a hit every normal component is zero.
    `SOC_ASSERT_IMP(a_miss_zero, clk, rst_n, m_tvalid && !m_tuser[0], m_tdata == 96'd0)

    // A stalled result keeps its contents.
    `SOC_ASSERT_NXT(a_hold, clk, rst_n, m_tvalid && !m_tready,
                    m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind sphere_obb_collision soc_checker u_soc_checker (.*);

@@ tb/sv/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [2:0] CFG_NONE_5 = 3'd5;
    localparam logic [2:0] CFG_NONE_7 = 3'd7;
    localparam int         QUERY_WAIT = 130;
    localparam int         PHASES     = 7;
    localparam int         PER_PHASE  = 137;
    localparam logic signed [31:0] I32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] I32_MIN = 32'sh8000_0000;
    localparam logic [30:0]        RAD_MAX = 31'h7FFF_FFFF;
    localparam int                 ONE     = 65536;

    typedef struct {
        logic        collided;
        logic        empty;
        logic [31:0] nx;
        logic [31:0] ny;
        logic [31:0] nz;
    } hit_t;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [30:0] rad;
        bit          typed;
        logic        collided;
        logic        empty;
    } row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    sphere_obb_collision u_dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Shadow copy of the block's bounds and registers.
    longint  lo_bound [3];
    longint  hi_bound [3];
    bit      loaded;
    longint  offs [3];
    longint  cosv;
    longint  sinv;

    hit_t    pending_hits [$];
    int      fails = 0;
    bit      quiet = 0;
    int      stall_left = 0;

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic void reset_bounds();
        for (int i = 0; i < 3; i++)
        begin
            lo_bound[i] = I32_MAX;
            hi_bound[i] = I32_MIN;
        end
        loaded = 0;
    endfunction

    // Returns 1 when the request yields a result, placed in h.
    function automatic bit collide_step(logic [1:0] kind, logic [31:0] px, logic [31:0] py,
                                        logic [31:0] pz, logic [30:0] rad, output hit_t h);
        longint pos [3];
        longint e [3];
        longint d [3];
        longint p [3];
        longint b [3];
        longint r [3];
        longint unsigned a;
        longint unsigned dist2;
        longint unsigned rad2;
        longint unsigned len;
        longint unsigned intr;
        longint unsigned q;
        logic [64:0] acc;
        logic [31:0] nrm [3];
        pos[0] = longint'($signed(px));
        pos[1] = longint'($signed(py));
        pos[2] = longint'($signed(pz));
        h = '{1'b0, 1'b0, 32'd0, 32'd0, 32'd0};
        if (kind == soc_pkg::REQ_VERTEX)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (pos[i] < lo_bound[i]) lo_bound[i] = pos[i];
                if (pos[i] > hi_bound[i]) hi_bound[i] = pos[i];
            end
            loaded = 1;
            return 0;
        end
        if (kind == soc_pkg::REQ_CLEAR)
        begin
            reset_bounds();
            return 0;
        end
        if (kind != soc_pkg::REQ_QUERY)
            return 0;
        if (!loaded)
        begin
            h.empty = 1'b1;
            return 1;
        end
        for (int i = 0; i < 3; i++)
        begin
            e[i] = (hi_bound[i] - lo_bound[i]) >>> 1;
            d[i] = pos[i] - (offs[i] + lo_bound[i] + e[i]);
        end
        p[0] = (d[0] * cosv - d[2] * sinv + 8192) >>> 14;
        p[1] = d[1];
        p[2] = (d[0] * sinv + d[2] * cosv + 8192) >>> 14;
        for (int i = 0; i < 3; i++)
        begin
            if (p[i] > e[i]) p[i] = e[i];
            else if (p[i] < -e[i]) p[i] = -e[i];
        end
        b[0] = (p[0] * cosv + p[2] * sinv + 8192) >>> 14;
        b[1] = p[1];
        b[2] = (p[2] * cosv - p[0] * sinv + 8192) >>> 14;
        dist2 = 0;
        for (int i = 0; i < 3; i++)
        begin
            r[i] = d[i] - b[i];
            a = (r[i] < 0) ? longint'(-r[i]) : r[i];
            if (a > 64'hFFFF_FFFF)
                dist2 = '1;
            else
            begin
                acc = {1'b0, dist2} + a * a;
                dist2 = acc[64] ? 64'hFFFF_FFFF_FFFF_FFFF : acc[63:0];
            end
        end
        rad2 = longint'(rad) * longint'(rad);
        if (dist2 > rad2)
            return 1;
        h.collided = 1'b1;
        len = int_sqrt(dist2);
        if (len == 0)
            return 1;
        intr = longint'(rad) - len;
        for (int i = 0; i < 3; i++)
        begin
            a = (r[i] < 0) ? longint'(-r[i]) : r[i];
            q = (a * intr) / len;
            nrm[i] = (r[i] < 0) ? 32'(-q) : 32'(q);
        end
        h.nx = nrm[0];
        h.ny = nrm[1];
        h.nz = nrm[2];
        return 1;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            soc_pkg::CFG_OFFSET_X: offs[0] = longint'($signed(val));
            soc_pkg::CFG_OFFSET_Y: offs[1] = longint'($signed(val));
            soc_pkg::CFG_OFFSET_Z: offs[2] = longint'($signed(val));
            soc_pkg::CFG_ROT_COS:  cosv = longint'($signed(val[15:0]));
            soc_pkg::CFG_ROT_SIN:  sinv = longint'($signed(val[15:0]));
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (QUERY_WAIT) @(posedge clk);
    endtask

    // Leaves s_tvalid high after the transaction so back-to-back items need no toggle.
    task automatic send_item(row_t it);
        hit_t h;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.kind;
        s_tdata <= {1'b0, it.rad, it.z, it.y, it.x};
        do
            @(posedge clk);
        while (!s_tready);
        if (collide_step(it.kind, it.x, it.y, it.z, it.rad, h))
        begin
            if (it.typed)
                h = '{it.collided, it.empty, 32'd0, 32'd0, 32'd0};
            pending_hits.push_back(h);
        end
    endtask

    function automatic logic [31:0] near(longint centre, int span);
        return 32'(centre + longint'($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic random_item(longint base);
        row_t it;
        int sel;
        sel = $urandom_range(0, 99);
        it.typed = 0;
        it.collided = 0;
        it.empty = 0;
        it.rad = $urandom_range(0, 3 * ONE);
        if (sel < 15)
        begin
            // Full-range noise so every bit of every field toggles.
            it.kind = 2'($urandom);
            it.x = $urandom;
            it.y = $urandom;
            it.z = $urandom;
            it.rad = 31'($urandom);
        end
        else if (sel < 55)
        begin
            it.kind = soc_pkg::REQ_VERTEX;
            it.x = near(base, 2 * ONE);
            it.y = near(base, 2 * ONE);
            it.z = near(base, 2 * ONE);
        end
        else if (sel < 95)
        begin
            it.kind = soc_pkg::REQ_QUERY;
            it.x = near(base + offs[0], 4 * ONE);
            it.y = near(base + offs[1], 4 * ONE);
            it.z = near(base + offs[2], 4 * ONE);
        end
        else
        begin
            it.kind = (sel < 98) ? soc_pkg::REQ_CLEAR : REQ_UNUSED;
            it.x = $urandom;
            it.y = $urandom;
            it.z = $urandom;
        end
        send_item(it);
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 4);
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        hit_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_hits.size() == 0)
            begin
                $error("result with no query outstanding");
                fails++;
            end
            else
            begin
                want = pending_hits.pop_front();
                if (m_tuser[0] !== want.collided)
                begin
                    $error("collided: expected %0d, got %0d", want.collided, m_tuser[0]);
                    fails++;
                end
                if (m_tuser[1] !== want.empty)
                begin
                    $error("empty_bounds: expected %0d, got %0d", want.empty, m_tuser[1]);
                    fails++;
                end
                if (m_tdata[31:0] !== want.nx)
                begin
                    $error("normal_x: expected %h, got %h", want.nx, m_tdata[31:0]);
                    fails++;
                end
                if (m_tdata[63:32] !== want.ny)
                begin
                    $error("normal_y: expected %h, got %h", want.ny, m_tdata[63:32]);
                    fails++;
                end
                if (m_tdata[95:64] !== want.nz)
                begin
                    $error("normal_z: expected %h, got %h", want.nz, m_tdata[95:64]);
                    fails++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        row_t directed [$];
        longint base;
        logic [31:0] phase_regs [5];
        directed = '{
            '{soc_pkg::REQ_QUERY,  32'd0, 32'd0, 32'd0, 31'd65536, 1, 1'b0, 1'b1},
            '{REQ_UNUSED, 32'd5, 32'd5, 32'd5, 31'd5, 0, 1'b0, 1'b0},
            '{soc_pkg::REQ_CLEAR,  32'd0, 32'd0, 32'd0, 31'd0, 0, 1'b0, 1'b0},
            '{soc_pkg::REQ_QUERY,  32'd1, 32'd1, 32'd1, RAD_MAX, 1, 1'b0, 1'b1},
            '{soc_pkg::REQ_VERTEX, -32'sd131072, -32'sd65536, -32'sd196608, 31'd0, 0,
              1'b0, 1'b0},
            '{soc_pkg::REQ_VERTEX, 32'sd131072, 32'sd65536, 32'sd196608, 31'd0, 0,
              1'b0, 1'b0},
            // Sphere centred in the box: a hit at zero distance, so no normal.
            '{soc_pkg::REQ_QUERY,  32'd0, 32'd0, 32'd0, 31'd65536, 1, 1'b1, 1'b0},
            '{soc_pkg::REQ_QUERY,  32'sd196608, 32'd0, 32'd0, 31'd131072, 0, 1'b0, 1'b0},
            '{soc_pkg::REQ_QUERY,  32'sd327680, 32'd0, 32'd0, 31'd65536, 1, 1'b0, 1'b0},
            '{soc_pkg::REQ_QUERY,  32'sd131072, 32'd0, 32'd0, 31'd0, 1, 1'b1, 1'b0},
            '{soc_pkg::REQ_QUERY,  32'sd150000, 32'sd70000, -32'sd200000, 31'd40000, 0,
              1'b0, 1'b0},
            '{soc_pkg::REQ_VERTEX, I32_MIN, I32_MIN, I32_MIN, RAD_MAX, 0, 1'b0, 1'b0},
            '{soc_pkg::REQ_VERTEX, I32_MAX, I32_MAX, I32_MAX, 31'd0, 0, 1'b0, 1'b0},
            '{soc_pkg::REQ_QUERY,  I32_MAX, I32_MIN, I32_MAX, RAD_MAX, 0, 1'b0, 1'b0},
            '{soc_pkg::REQ_CLEAR,  32'd0, 32'd0, 32'd0, 31'd0, 0, 1'b0, 1'b0},
            '{soc_pkg::REQ_VERTEX, I32_MIN, I32_MIN, I32_MIN, 31'd0, 0, 1'b0, 1'b0},
            // Distance from one corner of the range to the other saturates: never a hit.
            '{soc_pkg::REQ_QUERY,  I32_MAX, I32_MAX, I32_MAX, RAD_MAX, 1, 1'b0, 1'b0},
            '{soc_pkg::REQ_QUERY,  I32_MIN, I32_MIN, I32_MIN, 31'd0, 1, 1'b1, 1'b0},
            '{REQ_UNUSED, I32_MAX, I32_MAX, I32_MAX, RAD_MAX, 0, 1'b0, 1'b0},
            '{soc_pkg::REQ_CLEAR,  32'd0, 32'd0, 32'd0, 31'd0, 0, 1'b0, 1'b0}
        };
        offs = '{0, 0, 0};
        cosv = soc_pkg::ROT_COS_RESET;
        sinv = 0;
        reset_bounds();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send_item(directed[i]);
        wait_drained();
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: phase_regs = '{32'd70000, -32'sd50000, 32'd12345, 32'd11585, 32'd11585};
                1: phase_regs = '{I32_MAX, I32_MAX, I32_MAX, -32'sd16384, 32'd0};
                2: phase_regs = '{I32_MIN, I32_MIN, I32_MIN, 32'd0, 32'd16384};
                3: phase_regs = '{32'd0, 32'd0, 32'd0, 32'd16384, -32'sd16384};
                4: phase_regs = '{near(0, 8 * ONE), near(0, 8 * ONE), near(0, 8 * ONE),
                                  32'($signed(16'($urandom_range(0, 32768) - 16384))),
                                  32'($signed(16'($urandom_range(0, 32768) - 16384)))};
                5: phase_regs = '{-32'sd300000, 32'd65536, near(0, ONE), 32'd15137, -32'sd6270};
                default: phase_regs = '{32'd0, 32'd0, 32'd0, 32'd16384, 32'd0};
            endcase
            for (int k = 0; k < 5; k++)
                write_reg(3'(k), phase_regs[k]);
            if (ph == 3)
                write_reg(CFG_NONE_5, 32'hDEAD_BEEF);
            if (ph == PHASES - 1)
            begin
                write_reg(CFG_NONE_7, 32'h1234_5678);
                quiet = 1;
            end
            base = longint'($signed(near(0, 6 * ONE)));
            for (int n = 0; n < PER_PHASE; n++)
            begin
                random_item(base);
                if (n == PER_PHASE / 2 && ph == 2)
                begin
                    s_tvalid <= 1'b0;
                    do
                        @(posedge clk);
                    while (pending_hits.size() != 0);
                end
            end
            wait_drained();
        end
        if (fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
